// ----- hw/rtl/lsb_first_bit_packer_core_macros.svh -----
// Assertion helpers for the bit packer, clocked on clk and quiet during reset.
`ifndef LSB_FIRST_BIT_PACKER_CORE_MACROS_SVH
`define LSB_FIRST_BIT_PACKER_CORE_MACROS_SVH

// Same-cycle implication.
`define LBP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bit packer check failed");

// Next-cycle implication.
`define LBP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bit packer check failed");

`endif

// ----- hw/rtl/lbp_pkg.sv -----
`default_nettype none

package lbp_pkg;

	localparam int unsigned BYTE_BITS      = 8;
	localparam int unsigned VALUE_BITS     = 32;
	localparam int unsigned MAX_FIELD_BITS = 32;
	localparam int unsigned WIDTH_LIMIT    =
		(MAX_FIELD_BITS < VALUE_BITS) ? MAX_FIELD_BITS : VALUE_BITS;
	localparam int unsigned MAX_BYTES      = 4;

	typedef enum logic [1:0] {
		KIND_UNSIGNED = 2'd0,
		KIND_SIGNED   = 2'd1,
		KIND_FLUSH    = 2'd2,
		KIND_RESERVED = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_WIDTH = 2'd1,
		ST_NO_FIT    = 2'd2
	} status_t;

	// Outcome of one item: the results it yields and the state it leaves.
	typedef struct packed {
		logic [2:0]       n_res;
		status_t          status;
		logic [3:0][7:0]  bytes;
		logic             upd;
		logic [7:0]       next_partial;
		logic [2:0]       next_cnt;
	} pack_res_t;

	// All ones below bit w; all ones for w of 32 or more.
	function automatic logic [31:0] low_mask(input logic [5:0] w);
		logic [31:0] m;
		if (w >= 6'd32) begin
			m = '1;
		end else begin
			m = (32'd1 << w[4:0]) - 32'd1;
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lsb_first_bit_packer_core.sv -----
// LSB-first bit packer.
// Input channel (in_valid / in_stall): kind, value_bits, field_width. Kind 0
// writes an unsigned field, kind 1 a sign bit followed by the complement
// magnitude, kind 2 flushes a partial byte padded with zeros, kind 3 is ignored.
// Output channel (out_valid / out_stall): one transfer per completed byte,
// with status 0, or one transfer with out_byte 0 and an error status; last
// marks the final result of an item. A rejected item leaves the state as it was.
// Flow: an accepted item waits in the input register, is packed there in a single
// pass and moves into a four-byte result buffer as soon as the buffer is free;
// byte 0 of the buffer is the result on the output port.
// Throughput: the output port drains one result per cycle while out_stall is low,
// so an item with n results (1 to 4) holds the buffer until all n have transferred;
// items that yield no result never wait on the buffer. A new item is taken every
// cycle as long as the buffer drains in time.
// Reset (arst_n low): both registers empty, no partial bits pending.
// A stalled receiver holds the current result; an item with results then waits in
// the input register and in_stall rises until the buffer frees up.
`default_nettype none
`include "lsb_first_bit_packer_core_macros.svh"

module lsb_first_bit_packer_core
	import lbp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [31:0] value_bits,
	input  wire logic [5:0]  field_width,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic [1:0]       status,
	output logic             last
);

	// Input register.
	logic        valid_s1;
	kind_t       kind_s1;
	logic [31:0] value_s1;
	logic [5:0]  width_s1;

	// Packing state.
	logic [7:0]  partial_q;
	logic [2:0]  bit_cnt_q;

	// Result buffer: byte 0 is the one on the port.
	logic [3:0][7:0] buf_byte_q;
	status_t         buf_status_q;
	logic [2:0]      buf_left_q;

	pack_res_t res;
	logic      out_take;
	logic      buf_free;
	logic      commit;
	logic      in_take;

	// Packing datapath.
	logic        sign;
	logic [31:0] mag;
	logic [31:0] data;
	logic [39:0] acc;
	logic [5:0]  total;
	logic [7:0]  byte_sel;
	logic [7:0]  keep_mask;

	always_comb begin
		sign      = value_s1[31];
		mag       = sign ? ~value_s1 : value_s1;
		data      = (kind_s1 == KIND_SIGNED) ? {mag[30:0], sign} : value_s1;
		acc       = {32'd0, partial_q} | ({8'd0, data} << bit_cnt_q);
		total     = {3'd0, bit_cnt_q} + width_s1;
		case (total[5:3])
			3'd0: byte_sel = acc[7:0];
			3'd1: byte_sel = acc[15:8];
			3'd2: byte_sel = acc[23:16];
			3'd3: byte_sel = acc[31:24];
			default: byte_sel = acc[39:32];
		endcase
		keep_mask = 8'hFF >> (4'd8 - {1'b0, total[2:0]});

		res              = '0;
		res.status       = ST_OK;
		res.next_partial = partial_q;
		res.next_cnt     = bit_cnt_q;
		case (kind_s1)
			KIND_UNSIGNED, KIND_SIGNED: begin
				if (width_s1 > 6'(WIDTH_LIMIT) ||
				    (kind_s1 == KIND_SIGNED && width_s1 == 6'd0)) begin
					res.n_res  = 3'd1;
					res.status = ST_BAD_WIDTH;
				end else if ((kind_s1 == KIND_UNSIGNED &&
				              (value_s1 & ~low_mask(width_s1)) != 32'd0) ||
				             (kind_s1 == KIND_SIGNED &&
				              (mag & ~low_mask(width_s1 - 6'd1)) != 32'd0)) begin
					res.n_res  = 3'd1;
					res.status = ST_NO_FIT;
				end else begin
					res.n_res        = total[5:3];
					res.bytes        = acc[31:0];
					res.upd          = 1'b1;
					res.next_partial = byte_sel & keep_mask;
					res.next_cnt     = total[2:0];
				end
			end
			KIND_FLUSH: begin
				if (bit_cnt_q != 3'd0) begin
					res.n_res        = 3'd1;
					res.bytes[0]     = partial_q;
					res.upd          = 1'b1;
					res.next_partial = 8'd0;
					res.next_cnt     = 3'd0;
				end
			end
			default: begin
				// Reserved kind: drop without a trace.
			end
		endcase
	end

	// Handshakes. An item with no results never waits on the buffer.
	assign out_valid = (buf_left_q != 3'd0);
	assign out_take  = out_valid && !out_stall;
	assign buf_free  = (buf_left_q == 3'd0) || (buf_left_q == 3'd1 && out_take);
	assign commit    = valid_s1 && (res.n_res == 3'd0 || buf_free);
	assign in_stall  = valid_s1 && !commit;
	assign in_take   = in_valid && !in_stall;

	assign out_byte  = buf_byte_q[0];
	assign status    = buf_status_q;
	assign last      = (buf_left_q == 3'd1);

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload: load only on a transfer, hold otherwise.
	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1  <= kind_t'(kind);
			value_s1 <= value_bits;
			width_s1 <= field_width;
		end
	end

	// Packing state advances when a packed field or a pending flush leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= 8'd0;
			bit_cnt_q <= 3'd0;
		end else if (commit && res.upd) begin
			partial_q <= res.next_partial;
			bit_cnt_q <= res.next_cnt;
		end
	end

	// Result buffer count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_left_q <= 3'd0;
		end else if (commit && res.n_res != 3'd0) begin
			buf_left_q <= res.n_res;
		end else if (out_take) begin
			buf_left_q <= buf_left_q - 3'd1;
		end
	end

	// Result buffer payload: load a burst, or advance one byte per transfer.
	always_ff @(posedge clk) begin
		if (commit && res.n_res != 3'd0) begin
			buf_byte_q   <= res.bytes;
			buf_status_q <= res.status;
		end else if (out_take) begin
			buf_byte_q <= {8'd0, buf_byte_q[3:1]};
		end
	end

	// Checks.
	`LBP_ASSERT_NEXT(a_flush_clears, commit && kind_s1 == KIND_FLUSH,
		bit_cnt_q == 3'd0 && partial_q == 8'd0)
	`LBP_ASSERT_NOW(a_error_single, out_valid && buf_status_q != ST_OK,
		last && out_byte == 8'd0)
	`LBP_ASSERT_NEXT(a_burst_continues, out_take && !last, out_valid)
	`LBP_ASSERT_NEXT(a_item_held, valid_s1 && !commit,
		valid_s1 && $stable(value_s1) && $stable(width_s1))

endmodule

`default_nettype wire

// ----- sim/lsb_first_bit_packer_checker.sv -----
`timescale 1ns / 1ps

module lsb_first_bit_packer_checker
	import lbp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [31:0] value_bits,
	input  wire logic [5:0]  field_width,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [7:0]  out_byte,
	input  wire logic [1:0]  status,
	input  wire logic        last,
	output int               fail_count,
	output int               outstanding
);

	typedef struct packed {
		logic [7:0] data;
		status_t    st;
		logic       fin;
	} byte_result_t;

	byte_result_t awaited_bytes[$];
	logic [7:0]   held_bits;
	logic [2:0]   held_count;

	task automatic queue_error(input status_t code);
		awaited_bytes.push_back(byte_result_t'{8'h00, code, 1'b1});
	endtask

	// Append nbits to the held bits, queue every completed byte, keep the rest.
	task automatic pack_bits(input logic [63:0] bits, input int unsigned nbits);
		logic [63:0] acc;
		int unsigned total;
		acc = {56'd0, held_bits} | (bits << held_count);
		total = held_count + nbits;
		while (total >= BYTE_BITS) begin
			awaited_bytes.push_back(byte_result_t'{acc[7:0], ST_OK,
				(total - BYTE_BITS) < BYTE_BITS});
			acc = acc >> BYTE_BITS;
			total = total - BYTE_BITS;
		end
		held_bits = acc[7:0] & ((8'd1 << total) - 8'd1);
		held_count = total[2:0];
	endtask

	task automatic predict_item(input kind_t k, input logic [31:0] v, input logic [5:0] w);
		logic        sign;
		logic [31:0] mag;
		case (k)
			KIND_UNSIGNED: begin
				if (w > WIDTH_LIMIT)
					queue_error(ST_BAD_WIDTH);
				else if (w < VALUE_BITS && (v >> w) != 32'd0)
					queue_error(ST_NO_FIT);
				else
					pack_bits({32'd0, v}, w);
			end
			KIND_SIGNED: begin
				sign = v[31];
				mag = sign ? ~v : v;
				if (w == 6'd0 || w > WIDTH_LIMIT)
					queue_error(ST_BAD_WIDTH);
				else if ((mag >> (w - 6'd1)) != 32'd0)
					queue_error(ST_NO_FIT);
				else
					pack_bits({31'd0, mag, sign}, w);
			end
			KIND_FLUSH: begin
				if (held_count != 3'd0) begin
					awaited_bytes.push_back(byte_result_t'{held_bits, ST_OK, 1'b1});
					held_bits = '0;
					held_count = '0;
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		byte_result_t want;
		if (!arst_n) begin
			held_bits = '0;
			held_count = '0;
			awaited_bytes.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (in_valid && !in_stall)
				predict_item(kind_t'(kind), value_bits, field_width);
			if (out_valid && !out_stall) begin
				if (awaited_bytes.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected result byte %02h status %0d last %0b",
							$realtime, out_byte, status, last);
					fail_count++;
				end else begin
					want = awaited_bytes.pop_front();
					if (out_byte !== want.data || status !== want.st || last !== want.fin) begin
						if (fail_count < 10)
							$display("%0t: expected byte %02h status %0d last %0b, got byte %02h status %0d last %0b",
								$realtime, want.data, want.st, want.fin, out_byte, status, last);
						fail_count++;
					end
				end
			end
			outstanding = awaited_bytes.size();
		end
	end

endmodule

// ----- sim/lsb_first_bit_packer_core_test.sv -----
`timescale 1ns / 1ps

module lsb_first_bit_packer_core_test;
	import lbp_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [1:0]  kind = KIND_UNSIGNED;
	logic [31:0] value_bits = '0;
	logic [5:0]  field_width = '0;
	logic        out_stall = 1'b0;
	wire         in_stall;
	wire         out_valid;
	wire  [7:0]  out_byte;
	wire  [1:0]  status;
	wire         last;

	int fail_count;
	int outstanding;

	// Idle rates in percent; the sender rate is read only by the stimulus process.
	int send_idle = 16;
	int recv_idle = 73;

	// Long receiver hold-off, requested by the stimulus and counted down below.
	logic hold_go = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	lsb_first_bit_packer_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.value_bits  (value_bits),
		.field_width (field_width),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.status      (status),
		.last        (last)
	);

	lsb_first_bit_packer_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.value_bits  (value_bits),
		.field_width (field_width),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.status      (status),
		.last        (last),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// Receiver side: random stall at recv_idle percent, except during the one long
	// hold-off, which keeps stall high while hold_left counts down, so that the result
	// buffer and the input register both fill and the block must stall its input.
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= 59;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	// Offer one item and hold it until it transfers. Stall is looked at on the
	// falling edge, where it is settled for the coming rising edge, so the
	// decision never races the block's own update. Valid stays high from one
	// item to the next unless the sender chooses to idle.
	task automatic offer(input kind_t k, input logic [31:0] v, input logic [5:0] w);
		bit taken;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		value_bits <= v;
		field_width <= w;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	// Draw one random item. Most fields are well formed, so that they really
	// reach the packing path; the rest carry raw values that mostly fail the fit
	// test. A few widths lie above the limit, which also exercises bit 5.
	task automatic random_item(output kind_t k, output logic [31:0] v, output logic [5:0] w);
		int unsigned pick;
		logic [31:0] mag;
		pick = $urandom_range(99);
		if (pick < 10)
			k = KIND_FLUSH;
		else if (pick < 13)
			k = KIND_RESERVED;
		else if (pick < 57)
			k = KIND_UNSIGNED;
		else
			k = KIND_SIGNED;
		if ($urandom_range(19) == 0)
			w = 6'($urandom_range(63, 33));
		else
			w = 6'($urandom_range(32));
		v = $urandom;
		if ($urandom_range(4) != 0) begin
			if (k == KIND_UNSIGNED && w < 6'd32) begin
				v = v & ((32'd1 << w) - 32'd1);
			end else if (k == KIND_SIGNED && w != 6'd0 && w <= 6'd32) begin
				// Fit the magnitude into width-1 bits, then pick a sign.
				mag = v & ((32'd1 << (w - 6'd1)) - 32'd1);
				v = $urandom_range(1) ? ~mag : mag;
			end
		end
	endtask

	initial begin
		kind_t       k;
		logic [31:0] v;
		logic [5:0]  w;
		int          sent;
		int          drain;

		// Hold reset, then release it on a rising edge.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: extremes, every kind and the corner cases.
		offer(KIND_UNSIGNED, 32'h0000_0000, 6'd0);   // zero width, zero value: no result
		offer(KIND_UNSIGNED, 32'h0000_0001, 6'd0);   // zero width, nonzero value: no fit
		offer(KIND_UNSIGNED, 32'hFFFF_FFFF, 6'd32);  // full width: four bytes
		offer(KIND_UNSIGNED, 32'h0000_0000, 6'd33);  // just above the limit
		offer(KIND_UNSIGNED, 32'hFFFF_FFFF, 6'd63);  // widest encoding
		offer(KIND_UNSIGNED, 32'h0000_0001, 6'd1);
		offer(KIND_UNSIGNED, 32'h0000_0005, 6'd3);   // partial byte, no result
		offer(KIND_FLUSH,    32'h0000_0000, 6'd0);   // pad and emit
		offer(KIND_FLUSH,    32'hFFFF_FFFF, 6'd63);  // nothing pending: no result
		offer(KIND_SIGNED,   32'h0000_0000, 6'd0);   // signed zero width
		offer(KIND_SIGNED,   32'h0000_0000, 6'd1);   // sign bit only, zero
		offer(KIND_SIGNED,   32'hFFFF_FFFF, 6'd1);   // sign bit only, minus one
		offer(KIND_SIGNED,   32'h0000_0001, 6'd1);   // sign bit only, does not fit
		offer(KIND_SIGNED,   32'h8000_0000, 6'd32);  // most negative value
		offer(KIND_SIGNED,   32'h7FFF_FFFF, 6'd32);  // most positive value
		offer(KIND_SIGNED,   32'hFFFF_FFF0, 6'd5);   // minus sixteen in five bits
		offer(KIND_SIGNED,   32'hFFFF_FFEF, 6'd5);   // minus seventeen: does not fit
		offer(KIND_SIGNED,   32'h0000_0010, 6'd5);   // sixteen: does not fit
		offer(KIND_SIGNED,   32'h0000_0000, 6'd40);  // signed width above the limit
		offer(KIND_RESERVED, 32'hFFFF_FFFF, 6'd63);  // ignored
		offer(KIND_FLUSH,    32'h0000_0000, 6'd0);   // start the next field byte aligned
		offer(KIND_UNSIGNED, 32'h0000_007F, 6'd7);
		offer(KIND_UNSIGNED, 32'h0000_0000, 6'd32);  // seven pending plus 32 bits
		offer(KIND_UNSIGNED, 32'h8000_0000, 6'd31);  // top bit outside a 31-bit field
		offer(KIND_FLUSH,    32'h0000_0000, 6'd0);

		// Random part in three phases: sender light and receiver heavy, then the
		// other way round, then no idling at all with the long hold-off at its start.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle = 16;
					recv_idle <= 73;
				end
				1: begin
					send_idle = 73;
					recv_idle <= 16;
				end
				default: begin
					send_idle = 0;
					recv_idle <= 0;
					hold_go <= 1'b1;
				end
			endcase
			sent = 0;
			while (sent < 107) begin
				random_item(k, v, w);
				offer(k, v, w);
				if (k != KIND_RESERVED)
					sent++;
			end
		end
		in_valid <= 1'b0;

		// Drain everything still expected, then allow the pipeline to settle.
		drain = 0;
		while (outstanding != 0 && drain < 20000) begin
			@(posedge clk);
			drain++;
		end
		repeat (20) @(posedge clk);

		if (fail_count == 0 && outstanding == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#4_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/lbp_pkg.sv
hw/rtl/lsb_first_bit_packer_core.sv
sim/lsb_first_bit_packer_checker.sv
sim/lsb_first_bit_packer_core_test.sv
